### design/vqdm_pkg.sv
`default_nettype none

package vqdm_pkg;

   // Command codes carried in tuser of the request channel.
   localparam logic [2:0] CMD_INIT     = 3'd0;
   localparam logic [2:0] CMD_ALLOC    = 3'd1;
   localparam logic [2:0] CMD_RELEASE  = 3'd2;
   localparam logic [2:0] CMD_QUEUE    = 3'd3;
   localparam logic [2:0] CMD_COMPLETE = 3'd4;

   // Status codes carried in tuser of the response channel.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_BIG   = 2'd1;
   localparam logic [1:0] ST_SHORT     = 2'd2;
   localparam logic [1:0] ST_NO_WAITER = 2'd3;

   localparam logic [3:0] QSIZE_LOG2_RESET = 4'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // latch the request transaction
      logic wread;     // read the waiter entry of the used id
      logic exec;      // finish a single-result command and emit it
      logic pop_rd;    // read the link of the free-list head
      logic pop_emit;  // advance the free list and emit one descriptor
   } vqdm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_complete;  // request on the port is a complete command
      logic alloc_go;     // latched alloc passes all checks
      logic out_free;     // response register can take a transaction
      logic pop_last;     // current pop is the last of the chain
      logic clearing;     // clearing pass over the stores is running
   } vqdm_stat_type;

endpackage

`default_nettype wire

### design/vqdm_ctrl.sv
`default_nettype none

module vqdm_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  vqdm_pkg::vqdm_stat_type stat,
   output vqdm_pkg::vqdm_cmd_type  cmd
);
   import vqdm_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_WREAD    = 3'd1;
   localparam logic [2:0] S_EXEC     = 3'd2;
   localparam logic [2:0] S_POP_RD   = 3'd3;
   localparam logic [2:0] S_POP_EMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // Requests wait while the stores are being cleared.
            req_tready = !stat.clearing;
            if (req_tvalid && !stat.clearing) begin
               cmd.load = 1'b1;
               state_in = stat.in_complete ? S_WREAD : S_EXEC;
            end
         end
         S_WREAD: begin
            cmd.wread = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            if (stat.alloc_go) begin
               state_in = S_POP_RD;
            end else if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_POP_RD: begin
            cmd.pop_rd = 1'b1;
            state_in   = S_POP_EMIT;
         end
         S_POP_EMIT: begin
            if (stat.out_free) begin
               cmd.pop_emit = 1'b1;
               state_in     = stat.pop_last ? S_IDLE : S_POP_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### design/vqdm_dp.sv
`default_nettype none

module vqdm_dp #(
   parameter int QUEUE_DEPTH = 256,
   parameter int MAX_CHAIN   = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [2:0]             req_tuser,
   input  wire  [31:0]            req_tdata,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast,
   output logic [47:0]            rsp_tdata,
   input  wire                    csr_valid,
   input  wire  [3:0]             csr_wdata,
   input  vqdm_pkg::vqdm_cmd_type  cmd,
   output vqdm_pkg::vqdm_stat_type stat
);
   import vqdm_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int LNK_W = IDX_W + 1;
   localparam int DW    = LNK_W + 8;
   localparam int CHW   = $clog2(MAX_CHAIN + 1);
   localparam int MAX_LOG2 = $clog2(QUEUE_DEPTH + 1) - 1;
   localparam logic [LNK_W-1:0] LINK_END = LNK_W'(QUEUE_DEPTH);

   // Latched request fields.
   logic [2:0]       cmd_ff;
   logic [4:0]       n_ff;
   logic [7:0]       desc_ff;
   logic             head_ff;
   logic [7:0]       tag_ff;
   logic [7:0]       uid_ff;

   // Architectural state.
   logic [3:0]       qlog_ff;
   logic [LNK_W-1:0] free_head_ff, free_head_in;
   logic [LNK_W-1:0] free_count_ff, free_count_in;
   logic [15:0]      avail_ff, avail_in;
   logic [CHW-1:0]   pop_cnt_ff;
   logic [IDX_W-1:0] prev_ff;

   // Link store: one write port, one registered read port.
   logic [LNK_W-1:0] link_mem [QUEUE_DEPTH];
   logic [LNK_W-1:0] link_rd_ff;

   // Waiter store: valid bit above the tag.
   logic [8:0]       wait_mem [QUEUE_DEPTH];
   logic [8:0]       wait_rd_ff;

   // Clearing pass over both stores after reset and after init.
   logic             clr_busy_ff;
   logic             clr_init_ff;
   logic [IDX_W-1:0] clr_addr_ff;
   logic [LNK_W-1:0] clr_link;

   // Response register.
   logic             rsp_valid_ff;
   logic [1:0]       st_ff, st_in;
   logic [7:0]       oidx_ff, oidx_in;
   logic             olast_ff, olast_in;
   logic [7:0]       otag_ff, otag_in;
   logic             emit;

   // Derived sizes and masked indexes.
   logic [3:0]       qlog_eff;
   logic [LNK_W-1:0] qsize;
   logic [LNK_W-1:0] qmask;
   logic [IDX_W-1:0] desc_m;
   logic [IDX_W-1:0] uid_m;
   logic [IDX_W-1:0] pop_di;
   logic             too_big;
   logic             short_list;

   logic             link_we;
   logic [IDX_W-1:0] link_wa;
   logic [LNK_W-1:0] link_wd;
   logic             wait_set;
   logic             wait_clr;
   logic             wait_we;
   logic [IDX_W-1:0] wait_wa;
   logic [8:0]       wait_wd;

   // Queue size saturates at the largest power of two within the store.
   always_comb begin
      qlog_eff = (qlog_ff > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : qlog_ff;
      qsize    = LNK_W'(1) << qlog_eff;
      qmask    = qsize - LNK_W'(1);
      desc_m   = IDX_W'(DW'(desc_ff) & DW'(qmask));
      uid_m    = IDX_W'(DW'(uid_ff) & DW'(qmask));
      pop_di   = (free_head_ff < LINK_END) ? IDX_W'(free_head_ff) : '0;
      too_big  = (DW'(n_ff) > DW'(qsize)) || (32'(n_ff) > 32'(MAX_CHAIN));
      short_list = DW'(free_count_ff) < DW'(n_ff);
   end

   // Link value written by the clearing pass: zero after reset, the free list after init.
   always_comb begin
      if (!clr_init_ff) begin
         clr_link = '0;
      end else if (clr_addr_ff == '0) begin
         clr_link = LINK_END;
      end else begin
         clr_link = LNK_W'(clr_addr_ff) - LNK_W'(1);
      end
   end

   assign stat.in_complete = (req_tuser == CMD_COMPLETE);
   assign stat.alloc_go    = (cmd_ff == CMD_ALLOC) && !too_big && (n_ff != 5'd0) && !short_list;
   assign stat.out_free    = !rsp_valid_ff || rsp_tready;
   assign stat.pop_last    = (32'(pop_cnt_ff) + 32'd1) == 32'(n_ff);
   assign stat.clearing    = clr_busy_ff;

   assign emit = cmd.exec || cmd.pop_emit;

   // Link store write port: one write per cycle.
   always_comb begin
      link_we = 1'b0;
      link_wa = desc_m;
      link_wd = free_head_ff;
      if (clr_busy_ff) begin
         link_we = 1'b1;
         link_wa = clr_addr_ff;
         link_wd = clr_link;
      end else if (cmd.exec && (cmd_ff == CMD_RELEASE)) begin
         link_we = 1'b1;
      end else if (cmd.pop_rd && (pop_cnt_ff != '0)) begin
         link_we = 1'b1;
         link_wa = prev_ff;
         link_wd = LNK_W'(pop_di);
      end else if (cmd.pop_emit) begin
         link_we = 1'b1;
         link_wa = pop_di;
         link_wd = ((pop_cnt_ff != '0) && (pop_di == prev_ff)) ? LNK_W'(pop_di) : '0;
      end
   end

   assign wait_set = cmd.exec && (cmd_ff == CMD_QUEUE) && head_ff;
   assign wait_clr = cmd.exec && (cmd_ff == CMD_COMPLETE) && wait_rd_ff[8];

   // Waiter store write port: one write per cycle.
   always_comb begin
      wait_we = 1'b0;
      wait_wa = uid_m;
      wait_wd = '0;
      if (clr_busy_ff) begin
         wait_we = 1'b1;
         wait_wa = clr_addr_ff;
      end else if (wait_set) begin
         wait_we = 1'b1;
         wait_wa = desc_m;
         wait_wd = {1'b1, tag_ff};
      end else if (wait_clr) begin
         wait_we = 1'b1;
      end
   end

   // Next state and response contents for the command being finished.
   always_comb begin
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      avail_in      = avail_ff;
      st_in         = ST_OK;
      oidx_in       = '0;
      olast_in      = 1'b1;
      otag_in       = '0;
      if (cmd.pop_emit) begin
         // The whole chain is taken off the count with the first descriptor,
         // so every response of the alloc reports the count after the step.
         free_head_in = link_rd_ff;
         if (pop_cnt_ff == '0) begin
            free_count_in = free_count_ff - LNK_W'(n_ff);
         end
         oidx_in       = 8'(pop_di);
         olast_in      = stat.pop_last;
      end else if (cmd.exec) begin
         case (cmd_ff)
            CMD_INIT: begin
               free_head_in  = qmask;
               free_count_in = qsize;
               avail_in      = '0;
            end
            CMD_ALLOC: begin
               if (too_big) begin
                  st_in = ST_TOO_BIG;
               end else if (n_ff == 5'd0) begin
                  st_in = ST_OK;
               end else begin
                  st_in = ST_SHORT;
               end
            end
            CMD_RELEASE: begin
               free_head_in = LNK_W'(desc_m);
               if (free_count_ff < LINK_END) begin
                  free_count_in = free_count_ff + LNK_W'(1);
               end
            end
            CMD_QUEUE: begin
               oidx_in  = 8'(avail_ff & 16'(qmask));
               avail_in = avail_ff + 16'd1;
            end
            CMD_COMPLETE: begin
               if (wait_rd_ff[8]) begin
                  otag_in = wait_rd_ff[7:0];
               end else begin
                  st_in = ST_NO_WAITER;
               end
            end
            default: begin
               st_in = ST_OK;
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         qlog_ff       <= QSIZE_LOG2_RESET;
         free_head_ff  <= '0;
         free_count_ff <= '0;
         avail_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pop_cnt_ff    <= '0;
      end else begin
         if (csr_valid) begin
            qlog_ff <= csr_wdata;
         end
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         avail_ff      <= avail_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.load) begin
            pop_cnt_ff <= '0;
         end else if (cmd.pop_emit) begin
            pop_cnt_ff <= pop_cnt_ff + CHW'(1);
         end
      end
   end

   // Clearing pass: one entry of each store per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_init_ff <= 1'b0;
         clr_addr_ff <= '0;
      end else if (cmd.exec && (cmd_ff == CMD_INIT)) begin
         clr_busy_ff <= 1'b1;
         clr_init_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         if (clr_addr_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Request fields, chain tracking and response payload.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_tuser;
         n_ff    <= req_tdata[4:0];
         desc_ff <= req_tdata[12:5];
         head_ff <= req_tdata[13];
         tag_ff  <= req_tdata[21:14];
         uid_ff  <= req_tdata[29:22];
      end
      if (cmd.pop_emit) begin
         prev_ff <= pop_di;
      end
      if (emit) begin
         st_ff    <= st_in;
         oidx_ff  <= oidx_in;
         olast_ff <= olast_in;
         otag_ff  <= otag_in;
      end
   end

   // Link memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (cmd.pop_rd) begin
         link_rd_ff <= link_mem[pop_di];
      end
   end

   // Waiter memory.
   always_ff @(posedge clock) begin
      if (wait_we) begin
         wait_mem[wait_wa] <= wait_wd;
      end
      if (cmd.wread) begin
         wait_rd_ff <= wait_mem[uid_m];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = st_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {7'd0, avail_ff, 9'(free_count_ff), otag_ff, oidx_ff};

endmodule

`default_nettype wire

### design/virtqueue_descriptor_manager.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// req_      in         req_tvalid / req_tready   tuser cmd, tdata request fields
// rsp_      out        rsp_tvalid / rsp_tready   tuser status, tlast, tdata result fields
// csr_      in         csr_valid / csr_ready     csr_wdata queue size log2
//
// One request transaction is in flight at a time; the next is taken once the
// previous one has placed its last response in the output register.
// Single-result commands are latched, then executed; complete reads its waiter entry in between.
// An alloc that passes its checks then does, per descriptor, a link memory read, then the pop.
// Reset and init each start a clearing pass over all QUEUE_DEPTH entries (256 by default)
// of the link and waiter stores; requests wait until it ends.
// Reset is synchronous; a stalled response holds the datapath in place.

module virtqueue_descriptor_manager #(
   parameter int QUEUE_DEPTH = 256,
   parameter int MAX_CHAIN   = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [2:0]  req_tuser,  // cmd
   input  wire  [31:0] req_tdata,  // count, desc_index, is_head, waiter_tag, used_id
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [1:0]  rsp_tuser,  // status
   output logic        rsp_tlast,
   output logic [47:0] rsp_tdata,  // out_index, woken_tag, free_left, avail_index
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [3:0]  csr_wdata
);
   import vqdm_pkg::*;

   vqdm_cmd_type  cmd;
   vqdm_stat_type stat;

   assign csr_ready = 1'b1;

   vqdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   vqdm_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_CHAIN   (MAX_CHAIN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Only one request is worked on at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   // Error responses always end their transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tlast)
      else $error("error response without last");

   // A woken tag comes only with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata[15:8] == 8'd0))
      else $error("woken tag on an error response");

endmodule

`default_nettype wire

### test/tb_virtqueue_descriptor_manager.sv
`default_nettype none

module tb_virtqueue_descriptor_manager;
   timeunit 1ns;
   timeprecision 1ps;

   import vqdm_pkg::*;

   localparam int DEPTH      = 256;
   localparam int CHAIN_MAX  = 16;
   localparam int LINK_END   = DEPTH;
   localparam int CYCLE_CAP  = 400000;
   localparam logic [2:0] CMD_BAD_LO = 3'd5;
   localparam logic [2:0] CMD_BAD_HI = 3'd7;

   typedef struct {
      logic [1:0]  status;
      logic [7:0]  out_index;
      logic        last;
      logic [7:0]  woken_tag;
      logic [8:0]  free_left;
      logic [15:0] avail_index;
   } vq_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [2:0]  req_tuser;
   logic [31:0] req_tdata;   // count, desc_index, is_head, waiter_tag, used_id
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;   // status
   logic        rsp_tlast;
   logic [47:0] rsp_tdata;   // out_index, woken_tag, free_left, avail_index
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_wdata;

   virtqueue_descriptor_manager DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   // Mirror of the descriptor manager state.
   logic [8:0]  link_mem [DEPTH];
   logic [8:0]  waiter_mem [DEPTH];
   logic [8:0]  head_ptr;
   logic [8:0]  free_cnt;
   logic [15:0] avail_cnt;
   logic [15:0] used_cnt;
   logic [3:0]  size_log2;

   vq_result_type pending_results[$];
   int unsigned owned_descs[$];    // descriptors currently held by the driver
   int unsigned waiting_heads[$];  // descriptors queued with a waiter
   int unsigned error_count;
   int unsigned result_count;
   int unsigned item_count;
   int unsigned cycle_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned queue_size();
      return (size_log2 >= 4'd8) ? DEPTH : (1 << size_log2);
   endfunction

   function automatic void push_result(logic [1:0] status, logic [7:0] idx, logic last,
                                       logic [7:0] tag);
      vq_result_type r;
      r.status      = status;
      r.out_index   = idx;
      r.last        = last;
      r.woken_tag   = tag;
      r.free_left   = free_cnt;
      r.avail_index = avail_cnt;
      pending_results.push_back(r);
   endfunction

   // Computes the responses of one request and advances the mirrored state.
   function automatic void model_descriptor_step(logic [2:0] cmd, logic [4:0] count,
                                                 logic [7:0] desc_raw, logic is_head,
                                                 logic [7:0] tag, logic [7:0] used_raw);
      int unsigned qs;
      int unsigned m;
      int unsigned desc;
      int unsigned uid;
      int unsigned slot;
      int unsigned di;
      int unsigned got[CHAIN_MAX];
      logic [8:0] w;
      qs   = queue_size();
      m    = qs - 1;
      desc = desc_raw & m;
      uid  = used_raw & m;
      case (cmd)
         CMD_INIT: begin
            for (int i = 0; i < DEPTH; i++) begin
               link_mem[i]   = (i == 0) ? 9'(LINK_END) : 9'(i - 1);
               waiter_mem[i] = '0;
            end
            head_ptr  = 9'(m);
            free_cnt  = 9'(qs);
            avail_cnt = '0;
            used_cnt  = '0;
            owned_descs.delete();
            waiting_heads.delete();
            push_result(ST_OK, 8'd0, 1'b1, 8'd0);
         end
         CMD_ALLOC: begin
            if (count > qs || count > CHAIN_MAX) begin
               push_result(ST_TOO_BIG, 8'd0, 1'b1, 8'd0);
            end else if (count == 0) begin
               push_result(ST_OK, 8'd0, 1'b1, 8'd0);
            end else if (free_cnt < count) begin
               push_result(ST_SHORT, 8'd0, 1'b1, 8'd0);
            end else begin
               // Pop the chain, linking each descriptor to the one after it.
               for (int i = 0; i < count; i++) begin
                  di       = (head_ptr < DEPTH) ? head_ptr : 0;
                  got[i]   = di;
                  head_ptr = link_mem[di];
                  free_cnt = 9'(free_cnt - 1);
                  link_mem[di] = '0;
                  if (i > 0) link_mem[got[i-1]] = 9'(di);
               end
               for (int i = 0; i < count; i++) begin
                  push_result(ST_OK, 8'(got[i]), (i + 1 == count), 8'd0);
                  owned_descs.push_back(got[i]);
               end
            end
         end
         CMD_RELEASE: begin
            link_mem[desc] = head_ptr;
            head_ptr = 9'(desc);
            if (free_cnt < DEPTH) free_cnt = 9'(free_cnt + 1);
            push_result(ST_OK, 8'd0, 1'b1, 8'd0);
         end
         CMD_QUEUE: begin
            slot = avail_cnt & m;
            if (is_head) begin
               waiter_mem[desc] = {1'b1, tag};
               waiting_heads.push_back(desc);
            end
            avail_cnt = 16'(avail_cnt + 1);
            push_result(ST_OK, 8'(slot), 1'b1, 8'd0);
         end
         CMD_COMPLETE: begin
            w = waiter_mem[uid];
            used_cnt = 16'(used_cnt + 1);
            if (w[8]) begin
               waiter_mem[uid] = '0;
               push_result(ST_OK, 8'd0, 1'b1, w[7:0]);
            end else begin
               push_result(ST_NO_WAITER, 8'd0, 1'b1, 8'd0);
            end
         end
         default: push_result(ST_OK, 8'd0, 1'b1, 8'd0);
      endcase
   endfunction

   // Sends one request transaction, sometimes after a random idle gap.
   task automatic send_request(logic [2:0] cmd, logic [4:0] count, logic [7:0] desc,
                               logic is_head, logic [7:0] tag, logic [7:0] used_id);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      model_descriptor_step(cmd, count, desc, is_head, tag, used_id);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, used_id, tag, is_head, desc, count};
      do @(posedge clock); while (!req_tready);
      item_count++;
   endtask

   task automatic drop_valid();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      drop_valid();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes the queue size register while the block is idle.
   task automatic write_size(logic [3:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_log2 = value;
      owned_descs.delete();
      waiting_heads.delete();
   endtask

   // Response checker and receiver stall generator.
   always @(posedge clock) begin
      vq_result_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (pending_results.size() == 0) begin
               $error("unexpected response transaction");
               error_count++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_tuser !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[7:0] !== e.out_index) begin
                  $error("out_index: expected %0d, got %0d", e.out_index, rsp_tdata[7:0]);
                  error_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_tlast);
                  error_count++;
               end
               if (rsp_tdata[15:8] !== e.woken_tag) begin
                  $error("woken_tag: expected %0d, got %0d", e.woken_tag, rsp_tdata[15:8]);
                  error_count++;
               end
               if (rsp_tdata[24:16] !== e.free_left) begin
                  $error("free_left: expected %0d, got %0d", e.free_left, rsp_tdata[24:16]);
                  error_count++;
               end
               if (rsp_tdata[40:25] !== e.avail_index) begin
                  $error("avail_index: expected %0d, got %0d", e.avail_index,
                         rsp_tdata[40:25]);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic test_before_init();
      send_request(CMD_ALLOC, 5'd1, 8'd0, 1'b0, 8'd0, 8'd0);
      send_request(CMD_ALLOC, 5'd31, 8'd0, 1'b0, 8'd0, 8'd0);
      send_request(CMD_COMPLETE, 5'd0, 8'd0, 1'b0, 8'd0, 8'd255);
   endtask

   task automatic test_alloc_limits();
      send_request(CMD_INIT, 5'd0, 8'd0, 1'b0, 8'd0, 8'd0);
      send_request(CMD_ALLOC, 5'd0, 8'd0, 1'b0, 8'd0, 8'd0);
      send_request(CMD_ALLOC, 5'd17, 8'd0, 1'b0, 8'd0, 8'd0);
      send_request(CMD_ALLOC, 5'd16, 8'd0, 1'b0, 8'd0, 8'd0);
      send_request(CMD_ALLOC, 5'd16, 8'd0, 1'b0, 8'd0, 8'd0);
   endtask

   task automatic test_release_and_waiters();
      // Saturation of the free count on a full list.
      send_request(CMD_INIT, 5'd0, 8'd0, 1'b0, 8'd0, 8'd0);
      send_request(CMD_RELEASE, 5'd0, 8'd255, 1'b0, 8'd0, 8'd0);
      send_request(CMD_ALLOC, 5'd2, 8'd0, 1'b0, 8'd0, 8'd0);
      send_request(CMD_QUEUE, 5'd0, 8'd254, 1'b1, 8'hA5, 8'd0);
      send_request(CMD_QUEUE, 5'd0, 8'd253, 1'b0, 8'hFF, 8'd0);
      send_request(CMD_COMPLETE, 5'd0, 8'd0, 1'b0, 8'd0, 8'd254);
      send_request(CMD_COMPLETE, 5'd0, 8'd0, 1'b0, 8'd0, 8'd254);
      // A double release breaks the list until the next init.
      send_request(CMD_RELEASE, 5'd0, 8'd7, 1'b0, 8'd0, 8'd0);
      send_request(CMD_RELEASE, 5'd0, 8'd7, 1'b0, 8'd0, 8'd0);
      send_request(CMD_ALLOC, 5'd3, 8'd0, 1'b0, 8'd0, 8'd0);
   endtask

   task automatic test_unknown_cmds();
      for (logic [3:0] c = {1'b0, CMD_BAD_LO}; c <= {1'b0, CMD_BAD_HI}; c++)
         send_request(c[2:0], 5'h1F, 8'hFF, 1'b1, 8'hFF, 8'hFF);
   endtask

   task automatic test_random_traffic(int unsigned n_items);
      int unsigned r;
      int unsigned k;
      int unsigned m;
      logic [7:0] hi_bits;
      for (int unsigned i = 0; i < n_items; i++) begin
         m = queue_size() - 1;
         hi_bits = 8'($urandom) & ~8'(m);
         r = $urandom_range(99);
         if (i == n_items / 2) wait_drained();
         if (r < 32) begin
            send_request(CMD_ALLOC,
                         ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4)),
                         8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
         end else if (r < 57) begin
            if (owned_descs.size() != 0 && $urandom_range(9) != 0) begin
               k = $urandom_range(owned_descs.size() - 1);
               send_request(CMD_RELEASE, 5'($urandom), 8'(owned_descs[k]) | hi_bits,
                            1'($urandom), 8'($urandom), 8'($urandom));
               owned_descs.delete(k);
            end else begin
               send_request(CMD_RELEASE, 5'($urandom), 8'($urandom), 1'($urandom),
                            8'($urandom), 8'($urandom));
            end
         end else if (r < 77) begin
            send_request(CMD_QUEUE, 5'($urandom),
                         (owned_descs.size() != 0)
                            ? 8'(owned_descs[$urandom_range(owned_descs.size() - 1)]) | hi_bits
                            : 8'($urandom),
                         ($urandom_range(3) != 0), 8'($urandom), 8'($urandom));
         end else if (r < 94) begin
            if (waiting_heads.size() != 0 && $urandom_range(4) != 0) begin
               k = $urandom_range(waiting_heads.size() - 1);
               send_request(CMD_COMPLETE, 5'($urandom), 8'($urandom), 1'($urandom),
                            8'($urandom), 8'(waiting_heads[k]) | hi_bits);
               waiting_heads.delete(k);
            end else begin
               send_request(CMD_COMPLETE, 5'($urandom), 8'($urandom), 1'($urandom),
                            8'($urandom), 8'($urandom));
            end
         end else if (r < 97) begin
            send_request(CMD_INIT, 5'($urandom), 8'($urandom), 1'($urandom),
                         8'($urandom), 8'($urandom));
         end else begin
            send_request(3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)), 5'($urandom),
                         8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = '0;
      req_tdata     = '0;
      csr_valid     = 1'b0;
      csr_wdata     = '0;
      rsp_tready    = 1'b0;
      error_count   = 0;
      result_count  = 0;
      item_count    = 0;
      cycle_count   = 0;
      send_idle_pct = 16;
      recv_idle_pct = 56;
      for (int i = 0; i < DEPTH; i++) begin
         link_mem[i]   = '0;
         waiter_mem[i] = '0;
      end
      head_ptr  = '0;
      free_cnt  = '0;
      avail_cnt = '0;
      used_cnt  = '0;
      size_log2 = QSIZE_LOG2_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_before_init();
      test_alloc_limits();
      test_release_and_waiters();
      test_unknown_cmds();

      // Small queue: exercises short lists and count-above-size rejections.
      write_size(4'd3);
      send_request(CMD_INIT, 5'd0, 8'd0, 1'b0, 8'd0, 8'd0);
      test_random_traffic(50);

      // Oversized setting saturates to the full depth.
      write_size(4'd15);
      send_idle_pct = 56;
      recv_idle_pct = 16;
      send_request(CMD_INIT, 5'd0, 8'd0, 1'b0, 8'd0, 8'd0);
      test_random_traffic(50);

      // Size change without init, then the smallest queues.
      write_size(4'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(10);
      write_size(4'd0);
      send_request(CMD_INIT, 5'd0, 8'd0, 1'b0, 8'd0, 8'd0);
      test_random_traffic(20);
      write_size(4'd4);
      send_request(CMD_INIT, 5'd0, 8'd0, 1'b0, 8'd0, 8'd0);
      test_random_traffic(30);

      wait_drained();
      repeat (40) @(posedge clock);
      $display("Covered %0d requests and %0d responses over queue sizes 1 to 256,",
               item_count, result_count);
      $display("with sender and receiver stalls, list faults and waiter traffic.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
design/vqdm_pkg.sv
design/vqdm_ctrl.sv
design/vqdm_dp.sv
design/virtqueue_descriptor_manager.sv
test/tb_virtqueue_descriptor_manager.sv
